FILE: rtl/core/u16u8_pkg.sv
// ============================================================================
// u16u8_pkg
// Shared widths, register indexes and result codes of the UTF-16 to UTF-8
// encoder.
// ============================================================================
package u16u8_pkg;

  // Field widths of the stream and configuration ports, and the default byte-count width.
  localparam int unsigned CU_BITS             = 16;
  localparam int unsigned CAP_BITS            = 18;
  localparam int unsigned LEN_BITS            = 18;
  localparam int unsigned COUNT_BITS_DEFAULT  = 18;
  localparam int unsigned OUT_TDATA_BITS      = 32;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_STRICT_INVALID  = 1'b0,
    CFG_OUTPUT_CAPACITY = 1'b1
  } cfg_idx_e;

  // Kind of one result beat.
  typedef enum logic [0:0] {
    RES_BYTE   = 1'b0,
    RES_STATUS = 1'b1
  } res_kind_e;

  // End-of-string status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOBUF   = 2'd2
  } status_e;

endpackage

FILE: rtl/core/utf16_to_utf8_encoder.sv
// ============================================================================
// utf16_to_utf8_encoder
// Streams UTF-16 code units in and UTF-8 bytes plus an end-of-string status
// out, with surrogate pairing, replacement of lone surrogates and a capacity
// check on the output byte count.
// ============================================================================
// One code unit is accepted per beat on the slave stream; tlast marks the last
// unit of a string. Each unit is registered, then encoded and checked against
// the byte count and capacity combinationally, and its results (up to six
// bytes and, on the last unit, one status beat) are loaded into a run buffer.
// The run buffer sends one result per cycle on the master stream while
// m_axis_tready is high. A unit has one result for ASCII, two or three for
// the other planes of the BMP, four for a surrogate pair, up to seven with a
// flushed surrogate and a status beat. A unit with no results (a held high
// surrogate, or suppressed bytes after an error) loads no beat. The next unit
// is loaded into the run buffer in the cycle in which the last result of the
// previous one is accepted; the first result of a unit passes the input
// register and then the run buffer before it appears on the master stream.
// ============================================================================
module utf16_to_utf8_encoder #(
  parameter int unsigned COUNT_BITS = u16u8_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_idx_i,
  input  logic [u16u8_pkg::CAP_BITS-1:0]       cfg_wdata_i,
  // Slave stream. tdata: code_unit[15:0]. tlast: end_of_string.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [u16u8_pkg::CU_BITS-1:0]        s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // Master stream. tdata: out_byte[7:0], status[9:8], total_length[27:10],
  // zero[31:28]. tuser: result_kind. tlast: last_of_run.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [u16u8_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import u16u8_pkg::*;

  // Arithmetic width wide enough for both the count and the capacity, plus carry.
  localparam int unsigned WIDE = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;
  localparam logic [WIDE-1:0] CNT_MAX = {{(WIDE-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
  localparam logic [WIDE-1:0] LEN_MAX = {{(WIDE-LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};

  // Configuration registers.
  logic                 strict_q;
  logic [CAP_BITS-1:0]  cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
      cap_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STRICT_INVALID:  strict_q <= cfg_wdata_i[0];
        CFG_OUTPUT_CAPACITY: cap_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic               in_valid_q;
  logic [CU_BITS-1:0] cu_q;
  logic               eos_q;
  logic               run_load;

  assign s_axis_tready = !in_valid_q || run_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cu_q  <= s_axis_tdata;
      eos_q <= s_axis_tlast;
    end
  end

  // String state.
  logic                  held_q, held_d;
  logic [9:0]            hbits_q, hbits_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [1:0]            err_q, err_d;

  // Classification of the registered unit.
  logic        is_high, is_low, pair, held_lone, unit_lone, any_lone;
  logic [20:0] cp;
  logic [7:0]  ub [4];
  logic [2:0]  ku;

  assign is_high   = (cu_q[15:10] == 6'b110110);
  assign is_low    = (cu_q[15:10] == 6'b110111);
  assign pair      = held_q && is_low;
  assign held_lone = held_q && !is_low;
  assign unit_lone = (is_low && !held_q) || (is_high && eos_q);
  assign any_lone  = held_lone || unit_lone;
  assign cp        = 21'h10000 + {1'b0, hbits_q, cu_q[9:0]};

  // Bytes of the unit itself.
  always_comb begin
    ub[0] = 8'h00;
    ub[1] = 8'h00;
    ub[2] = 8'h00;
    ub[3] = 8'h00;
    ku    = 3'd0;
    if (pair) begin
      ub[0] = {5'b11110, cp[20:18]};
      ub[1] = {2'b10, cp[17:12]};
      ub[2] = {2'b10, cp[11:6]};
      ub[3] = {2'b10, cp[5:0]};
      ku    = 3'd4;
    end else if (unit_lone) begin
      ub[0] = 8'hEF;
      ub[1] = 8'hBF;
      ub[2] = 8'hBD;
      ku    = 3'd3;
    end else if (is_high) begin
      ku    = 3'd0;
    end else if (cu_q[15:7] == 9'd0) begin
      ub[0] = cu_q[7:0];
      ku    = 3'd1;
    end else if (cu_q[15:11] == 5'd0) begin
      ub[0] = {3'b110, cu_q[10:6]};
      ub[1] = {2'b10, cu_q[5:0]};
      ku    = 3'd2;
    end else begin
      ub[0] = {4'b1110, cu_q[15:12]};
      ub[1] = {2'b10, cu_q[11:6]};
      ub[2] = {2'b10, cu_q[5:0]};
      ku    = 3'd3;
    end
  end

  // Candidate bytes: a flushed high surrogate comes first, then the unit.
  logic [7:0] cand [6];
  logic [2:0] k;

  always_comb begin
    if (held_lone) begin
      cand[0] = 8'hEF;
      cand[1] = 8'hBF;
      cand[2] = 8'hBD;
      cand[3] = ub[0];
      cand[4] = ub[1];
      cand[5] = ub[2];
      k       = ku + 3'd3;
    end else begin
      cand[0] = ub[0];
      cand[1] = ub[1];
      cand[2] = ub[2];
      cand[3] = ub[3];
      cand[4] = 8'h00;
      cand[5] = 8'h00;
      k       = ku;
    end
  end

  // Strict check, capacity check and byte count for the whole unit.
  logic [WIDE-1:0] cnt_w, cap_w, k_w, sum_w, avail_w, cnt_new_w, len_w;
  logic [2:0]      n_emit;
  logic [1:0]      err_new;

  assign cnt_w = WIDE'(count_q);
  assign cap_w = WIDE'(cap_q);
  assign k_w   = WIDE'(k);
  assign sum_w = cnt_w + k_w;

  always_comb begin
    n_emit    = 3'd0;
    err_new   = err_q;
    cnt_new_w = cnt_w;
    avail_w   = (cap_w > cnt_w) ? (cap_w - cnt_w) : '0;
    if (err_q != ST_OK) begin
      n_emit = 3'd0;
    end else if (strict_q && any_lone) begin
      err_new = ST_INVALID;
    end else if ((cap_q == '0) || (cap_w > CNT_MAX)) begin
      // Count-only, or a capacity the saturated count can never reach.
      n_emit    = (cap_q == '0) ? 3'd0 : k;
      cnt_new_w = (sum_w > CNT_MAX) ? CNT_MAX : sum_w;
    end else begin
      if (k_w <= avail_w) begin
        n_emit = k;
      end else begin
        n_emit  = avail_w[2:0];
        err_new = ST_NOBUF;
      end
      cnt_new_w = cnt_w + WIDE'(n_emit);
    end
  end

  assign len_w = (cnt_new_w > LEN_MAX) ? LEN_MAX : cnt_new_w;

  // Run buffer holding the results of one unit.
  logic                run_valid_q;
  logic [7:0]          rbytes_q [6];
  logic [2:0]          nb_q, total_q, idx_q;
  logic [1:0]          rstatus_q;
  logic [LEN_BITS-1:0] rlen_q;
  logic                run_last, run_done;
  logic [2:0]          total_new;

  assign run_last  = (idx_q == (total_q - 3'd1));
  assign run_done  = run_valid_q && m_axis_tready && run_last;
  assign run_load  = in_valid_q && (!run_valid_q || run_done);
  assign total_new = n_emit + {2'b00, eos_q};

  // Next string state; the end mark starts a fresh string.
  always_comb begin
    held_d  = held_q;
    hbits_d = hbits_q;
    count_d = count_q;
    err_d   = err_q;
    if (run_load) begin
      if (eos_q) begin
        held_d  = 1'b0;
        hbits_d = '0;
        count_d = '0;
        err_d   = ST_OK;
      end else begin
        held_d  = is_high && !pair;
        hbits_d = (is_high && !pair) ? cu_q[9:0] : hbits_q;
        count_d = cnt_new_w[COUNT_BITS-1:0];
        err_d   = err_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      hbits_q <= '0;
      count_q <= '0;
      err_q   <= ST_OK;
    end else begin
      held_q  <= held_d;
      hbits_q <= hbits_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  // Run buffer control: load a new unit or step to the next beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
      total_q     <= '0;
    end else if (run_load) begin
      run_valid_q <= (total_new != 3'd0);
      idx_q       <= '0;
      total_q     <= total_new;
    end else if (run_done) begin
      run_valid_q <= 1'b0;
    end else if (run_valid_q && m_axis_tready) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  // Run buffer payload.
  always_ff @(posedge clk_i) begin
    if (run_load) begin
      for (int i = 0; i < 6; i++) begin
        rbytes_q[i] <= cand[i];
      end
      nb_q      <= n_emit;
      rstatus_q <= err_new;
      rlen_q    <= (err_new == ST_OK) ? len_w[LEN_BITS-1:0] : '0;
    end
  end

  // Result beat selection.
  logic       is_byte;
  logic [2:0] sel;
  logic [7:0] obyte;

  assign is_byte = (idx_q < nb_q);
  assign sel     = is_byte ? idx_q : 3'd0;
  assign obyte   = rbytes_q[sel];

  assign m_axis_tvalid = run_valid_q;
  assign m_axis_tuser  = is_byte ? RES_BYTE : RES_STATUS;
  assign m_axis_tlast  = run_last;
  assign m_axis_tdata  = is_byte ? {4'b0000, {LEN_BITS{1'b0}}, 2'b00, obyte}
                                 : {4'b0000, rlen_q, rstatus_q, 8'h00};

  // A status beat only ever closes a run, and runs never overrun their length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("status beat is not the last of its run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> (idx_q < total_q) && (nb_q <= total_q))
    else $error("run index beyond run length");

  // A waiting result is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q && !m_axis_tready |=> run_valid_q && (idx_q == $past(idx_q)))
    else $error("stalled result lost");

  // The end mark clears the string state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_load && eos_q |=> (count_q == '0) && (err_q == ST_OK) && !held_q)
    else $error("string state not cleared after end mark");

  // Bytes are only sent while no error is recorded for the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_load && (err_q != ST_OK) |-> (n_emit == 3'd0))
    else $error("byte sent after an error");

endmodule
